// ===== hw/rtl/ttc_pkg.sv =====
package ttc_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;

  // cordic datapath and angle register widths
  localparam int DW    = 36;
  localparam int AW    = 34;
  localparam int MBW   = 33;
  localparam int PW    = DW + MBW;
  localparam int ACW   = PW + 1;
  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [31:0] GAIN_Q30  = 32'd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [31:0] ARC_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_COEF   = 2'd1,
    CFG_ROT    = 2'd2,
    CFG_DECL   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CM_VECTOR = 1'b0,
    CM_ROTATE = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SMUL,
    S_SACC,
    S_ROLL_GO,
    S_ROLL_WAIT,
    S_SQ_M1,
    S_SQ_M2,
    S_SQ_LD,
    S_SQRT,
    S_PITCH_GO,
    S_PITCH_WAIT,
    S_SC1_GO,
    S_SC1_WAIT,
    S_TURN1,
    S_SC2_GO,
    S_SC2_WAIT,
    S_TURN2,
    S_HEAD_GO,
    S_HEAD_WAIT,
    S_FIN
  } state_e;

  // raw 16-bit sample to 32-bit fixed point
  function automatic logic signed [31:0] load_sample(logic signed [15:0] raw);
    logic signed [31:0] s;
    s = 32'(raw);
    if (SAMPLE_BITS < 16) begin
      s = (s >>> (16 - SAMPLE_BITS)) <<< (32 - SAMPLE_BITS);
    end else begin
      s = s <<< (32 - SAMPLE_BITS);
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/ttc_if.sv =====
interface ttc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] field_x;
  logic signed [15:0] field_y;
  logic signed [15:0] field_z;
  logic               field_present;
  logic               restart;

  modport source (
    output valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
           field_present, restart,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, field_x, field_y, field_z,
           field_present, restart,
    output ready
  );
endinterface

interface ttc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] heading;
  logic               heading_valid;

  modport source (
    output valid, roll, pitch, heading, heading_valid,
    input  ready
  );
  modport sink (
    input  valid, roll, pitch, heading, heading_valid,
    output ready
  );
endinterface

// ===== hw/rtl/ttc_cordic.sv =====
module ttc_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ttc_pkg::cordic_ctl_t              ctl_i,
  input  logic signed [ttc_pkg::DW-1:0]     x_i,
  input  logic signed [ttc_pkg::DW-1:0]     y_i,
  input  logic [31:0]                       ang_i,
  output logic                              done_o,
  output logic signed [ttc_pkg::DW-1:0]     x_o,
  output logic signed [ttc_pkg::DW-1:0]     y_o,
  output logic [31:0]                       ang_o
);

  localparam logic [ttc_pkg::CNT_W-1:0] LAST = ttc_pkg::CNT_W'(ttc_pkg::CORDIC_STEPS - 1);

  logic                              busy_q, done_q, flip_q, zero_q;
  logic [ttc_pkg::CNT_W-1:0]         step_q;
  ttc_pkg::cordic_mode_e             mode_q;
  logic signed [ttc_pkg::DW-1:0]     x_q, y_q, dx, dy;
  logic signed [ttc_pkg::AW-1:0]     z_q, tab;
  logic                              up;
  logic                              flip_in;
  logic [31:0]                       ang_fold;

  assign tab      = ttc_pkg::AW'(ttc_pkg::ARC_TAB[step_q]);
  assign dx       = y_q >>> step_q;
  assign dy       = x_q >>> step_q;
  // both modes turn the same way: vector when y is positive, rotate when z is negative
  assign up       = (mode_q == ttc_pkg::CM_VECTOR) ? (y_q > 0) : (z_q < 0);
  assign flip_in  = ang_i[30] ^ ang_i[31];
  assign ang_fold = ang_i ^ {flip_in, 31'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      mode_q <= ctl_i.mode;
      if (ctl_i.mode == ttc_pkg::CM_VECTOR) begin
        flip_q <= 1'b0;
        zero_q <= (x_i == '0) && (y_i == '0);
        if (x_i < 0) begin
          x_q <= -x_i;
          y_q <= -y_i;
          z_q <= ttc_pkg::AW'(ttc_pkg::HALF_TURN);
        end else begin
          x_q <= x_i;
          y_q <= y_i;
          z_q <= '0;
        end
      end else begin
        flip_q <= flip_in;
        zero_q <= 1'b0;
        x_q    <= ttc_pkg::DW'(ttc_pkg::GAIN_Q30);
        y_q    <= '0;
        z_q    <= ttc_pkg::AW'($signed(ang_fold));
      end
    end else if (busy_q) begin
      if (up) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - tab;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = flip_q ? -x_q : x_q;
  assign y_o    = flip_q ? -y_q : y_q;
  assign ang_o  = zero_q ? 32'd0 : z_q[31:0];

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("cordic started while busy");
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !ctl_i.start && step_q == LAST |=> done_q && !busy_q)
    else $error("cordic did not finish after last step");
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && zero_q |-> mode_q == ttc_pkg::CM_VECTOR)
    else $error("zero vector flag in rotation mode");
`endif

endmodule

// ===== hw/rtl/tilt_compensated_compass.sv =====
// tilt compensated compass
// in_i takes one word per sample: three accelerometer axes, three magnetometer
// axes with field_present, and restart to load the sample without smoothing.
// out_o gives roll, pitch, heading and heading_valid as 16-bit binary angles.
// cfg_we_i/cfg_idx_i/cfg_data_i write enable, smoothing_coef, screen_rotation
// and declination; write them only while the block is idle.
// one word is worked at a time: in_i.ready is high only in the idle state.
// out_o.valid rises on the edge that returns the block to idle, where the next
// word can then be taken. each word takes a multiply and an accumulate state
// per smoothed axis, a 32-step square root, and the shared cordic for each
// atan2 and each sine/cosine pair (up to five uses), plus a turn on the shared
// multiplier for each field rotation.
// with enable low a word is taken and dropped, giving no result.
// the result sits in an output register; if the receiver stalls, the next
// word is still taken and worked, and holds at its end until the output frees.
// reset clears the smoothed axes, sets the registers to their defaults and
// marks the next sample to be taken whole.
module tilt_compensated_compass (
  input  logic             clk_i,
  input  logic             rst_ni,
  ttc_in_if.sink           in_i,
  ttc_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int DW  = ttc_pkg::DW;
  localparam int MBW = ttc_pkg::MBW;
  localparam int PW  = ttc_pkg::PW;
  localparam int ACW = ttc_pkg::ACW;

  ttc_pkg::state_e state_q, state_d;

  logic               enable_q, first_q;
  logic [15:0]        coef_q;
  logic [1:0]         rot_q;
  logic signed [15:0] decl_q;

  logic signed [15:0] smp_q [6];
  logic               present_q, whole_q;
  logic signed [31:0] sm_q [6];
  logic [2:0]         idx_q;
  logic [2:0]         ph_q;

  logic signed [DW-1:0]  mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_q;
  logic signed [ACW-1:0] acc_q, diff_v, sum_v;
  logic signed [DW-1:0]  tmp_q, fx_q, fy_q, fz_q;

  logic [63:0] sq_n_q, sq_r_q, sq_bit, sq_t;
  logic [4:0]  sq_k_q;

  logic [31:0] roll_q, pitch_q, head_q;

  logic signed [32:0] src_x, src_y, ox, oy;
  logic signed [31:0] s_cur, c_cur;
  logic signed [32:0] s_diff;
  logic signed [DW-1:0] ta, tb;

  ttc_pkg::cordic_ctl_t  cctl;
  logic signed [DW-1:0]  cx_i, cy_i, cx_o, cy_o;
  logic [31:0]           cang_i, cang_o;
  logic                  cdone;

  logic in_acc, fin_ok, out_valid_q;
  logic [31:0] roll_r, pitch_r, head_r;
  logic signed [15:0] p16, p_clamp;
  logic signed [15:0] roll_out_q, pitch_out_q, head_out_q;
  logic               hv_out_q;

  assign in_i.ready = (state_q == ttc_pkg::S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign fin_ok     = !out_valid_q || out_o.ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      coef_q   <= 16'd655;
      rot_q    <= 2'd0;
      decl_q   <= '0;
      first_q  <= 1'b1;
    end else begin
      if (in_acc && enable_q) begin
        first_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (ttc_pkg::cfg_idx_e'(cfg_idx_i))
          ttc_pkg::CFG_ENABLE: begin
            if (cfg_data_i[0] != enable_q) first_q <= 1'b1;
            enable_q <= cfg_data_i[0];
          end
          ttc_pkg::CFG_COEF: coef_q <= cfg_data_i;
          ttc_pkg::CFG_ROT:  rot_q  <= cfg_data_i[1:0];
          ttc_pkg::CFG_DECL: decl_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // screen orientation of the accel or field x/y pair
  assign src_x = (state_q == ttc_pkg::S_TURN1) ? 33'(sm_q[3]) : 33'(sm_q[0]);
  assign src_y = (state_q == ttc_pkg::S_TURN1) ? 33'(sm_q[4]) : 33'(sm_q[1]);

  always_comb begin
    unique case (rot_q)
      2'd1: begin ox = src_y;  oy = -src_x; end
      2'd2: begin ox = -src_x; oy = -src_y; end
      2'd3: begin ox = -src_y; oy = src_x;  end
      default: begin ox = src_x; oy = src_y; end
    endcase
  end

  // shared multiplier operands
  assign c_cur  = sm_q[idx_q];
  assign s_cur  = ttc_pkg::load_sample(smp_q[idx_q]);
  assign s_diff = 33'(s_cur) - 33'(c_cur);
  assign ta     = (state_q == ttc_pkg::S_TURN1) ? DW'(ox) : fy_q;
  assign tb     = (state_q == ttc_pkg::S_TURN1) ? DW'(oy) : fz_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ttc_pkg::S_SMUL: begin
        mul_a = DW'(s_diff);
        mul_b = {17'b0, coef_q};
      end
      ttc_pkg::S_SQ_M1: begin
        mul_a = DW'(ox);
        mul_b = ox;
      end
      ttc_pkg::S_SQ_M2: begin
        mul_a = DW'(oy);
        mul_b = oy;
      end
      ttc_pkg::S_TURN1, ttc_pkg::S_TURN2: begin
        case (ph_q)
          3'd0: begin mul_a = ta; mul_b = cx_o[MBW-1:0]; end
          3'd1: begin mul_a = tb; mul_b = cy_o[MBW-1:0]; end
          3'd2: begin mul_a = ta; mul_b = cy_o[MBW-1:0]; end
          3'd3: begin mul_a = tb; mul_b = cx_o[MBW-1:0]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign diff_v = acc_q - ACW'(prod_q);
  assign sum_v  = acc_q + ACW'(prod_q);
  assign sq_bit = 64'h4000_0000_0000_0000 >> {sq_k_q, 1'b0};
  assign sq_t   = sq_r_q + sq_bit;

  // cordic requests
  always_comb begin
    cctl   = '{start: 1'b0, mode: ttc_pkg::CM_VECTOR};
    cx_i   = '0;
    cy_i   = '0;
    cang_i = '0;
    case (state_q)
      ttc_pkg::S_ROLL_GO: begin
        cctl.start = 1'b1;
        cx_i       = DW'(oy);
        cy_i       = -DW'(ox);
      end
      ttc_pkg::S_PITCH_GO: begin
        cctl.start = 1'b1;
        cx_i       = DW'(sq_r_q[31:0]);
        cy_i       = -DW'(sm_q[2]);
      end
      ttc_pkg::S_SC1_GO: begin
        cctl   = '{start: 1'b1, mode: ttc_pkg::CM_ROTATE};
        cang_i = 32'd0 - roll_q;
      end
      ttc_pkg::S_SC2_GO: begin
        cctl   = '{start: 1'b1, mode: ttc_pkg::CM_ROTATE};
        cang_i = pitch_q;
      end
      ttc_pkg::S_HEAD_GO: begin
        cctl.start = 1'b1;
        cx_i       = fz_q;
        cy_i       = -fx_q;
      end
      default: ;
    endcase
  end

  ttc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .x_i    (cx_i),
    .y_i    (cy_i),
    .ang_i  (cang_i),
    .done_o (cdone),
    .x_o    (cx_o),
    .y_o    (cy_o),
    .ang_o  (cang_o)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttc_pkg::S_IDLE:       if (in_acc && enable_q) state_d = ttc_pkg::S_SMUL;
      ttc_pkg::S_SMUL:       state_d = ttc_pkg::S_SACC;
      ttc_pkg::S_SACC: begin
        if (idx_q == 3'd5 || (idx_q == 3'd2 && !present_q)) state_d = ttc_pkg::S_ROLL_GO;
        else state_d = ttc_pkg::S_SMUL;
      end
      ttc_pkg::S_ROLL_GO:    state_d = ttc_pkg::S_ROLL_WAIT;
      ttc_pkg::S_ROLL_WAIT:  if (cdone) state_d = ttc_pkg::S_SQ_M1;
      ttc_pkg::S_SQ_M1:      state_d = ttc_pkg::S_SQ_M2;
      ttc_pkg::S_SQ_M2:      state_d = ttc_pkg::S_SQ_LD;
      ttc_pkg::S_SQ_LD:      state_d = ttc_pkg::S_SQRT;
      ttc_pkg::S_SQRT:       if (sq_k_q == 5'd31) state_d = ttc_pkg::S_PITCH_GO;
      ttc_pkg::S_PITCH_GO:   state_d = ttc_pkg::S_PITCH_WAIT;
      ttc_pkg::S_PITCH_WAIT: begin
        if (cdone) state_d = present_q ? ttc_pkg::S_SC1_GO : ttc_pkg::S_FIN;
      end
      ttc_pkg::S_SC1_GO:     state_d = ttc_pkg::S_SC1_WAIT;
      ttc_pkg::S_SC1_WAIT:   if (cdone) state_d = ttc_pkg::S_TURN1;
      ttc_pkg::S_TURN1:      if (ph_q == 3'd4) state_d = ttc_pkg::S_SC2_GO;
      ttc_pkg::S_SC2_GO:     state_d = ttc_pkg::S_SC2_WAIT;
      ttc_pkg::S_SC2_WAIT:   if (cdone) state_d = ttc_pkg::S_TURN2;
      ttc_pkg::S_TURN2:      if (ph_q == 3'd4) state_d = ttc_pkg::S_HEAD_GO;
      ttc_pkg::S_HEAD_GO:    state_d = ttc_pkg::S_HEAD_WAIT;
      ttc_pkg::S_HEAD_WAIT:  if (cdone) state_d = ttc_pkg::S_FIN;
      ttc_pkg::S_FIN:        if (fin_ok) state_d = ttc_pkg::S_IDLE;
      default:               state_d = ttc_pkg::S_IDLE;
    endcase
  end

  // smoothed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) sm_q[i] <= '0;
    end else if (state_q == ttc_pkg::S_SACC) begin
      sm_q[idx_q] <= whole_q ? s_cur : c_cur + prod_q[47:16];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      smp_q[0]  <= in_i.accel_x;
      smp_q[1]  <= in_i.accel_y;
      smp_q[2]  <= in_i.accel_z;
      smp_q[3]  <= in_i.field_x;
      smp_q[4]  <= in_i.field_y;
      smp_q[5]  <= in_i.field_z;
      present_q <= in_i.field_present;
      whole_q   <= in_i.restart || first_q;
      idx_q     <= '0;
    end
    case (state_q)
      ttc_pkg::S_SACC:      idx_q <= idx_q + 3'd1;
      ttc_pkg::S_ROLL_WAIT: if (cdone) roll_q <= cang_o;
      ttc_pkg::S_SQ_M2:     acc_q <= ACW'(prod_q);
      ttc_pkg::S_SQ_LD: begin
        sq_n_q <= sum_v[63:0];
        sq_r_q <= '0;
        sq_k_q <= '0;
      end
      ttc_pkg::S_SQRT: begin
        sq_k_q <= sq_k_q + 5'd1;
        if (sq_n_q >= sq_t) begin
          sq_n_q <= sq_n_q - sq_t;
          sq_r_q <= (sq_r_q >> 1) + sq_bit;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
      end
      ttc_pkg::S_PITCH_WAIT: if (cdone) pitch_q <= cang_o;
      ttc_pkg::S_SC1_GO, ttc_pkg::S_SC2_GO: ph_q <= '0;
      ttc_pkg::S_TURN1, ttc_pkg::S_TURN2: begin
        ph_q <= ph_q + 3'd1;
        case (ph_q)
          3'd1, 3'd3: acc_q <= ACW'(prod_q);
          3'd2:       tmp_q <= diff_v[DW+29:30];
          3'd4: begin
            if (state_q == ttc_pkg::S_TURN1) begin
              fx_q <= tmp_q;
              fy_q <= sum_v[DW+29:30];
              fz_q <= DW'(sm_q[5]);
            end else begin
              fy_q <= tmp_q;
              fz_q <= sum_v[DW+29:30];
            end
          end
          default: ;
        endcase
      end
      ttc_pkg::S_HEAD_WAIT: if (cdone) head_q <= cang_o;
      default: ;
    endcase
  end

  // result rounding
  assign roll_r  = roll_q + 32'h0000_8000;
  assign pitch_r = pitch_q + 32'h0000_8000;
  assign head_r  = head_q + 32'h0000_8000;
  assign p16     = pitch_r[31:16];
  assign p_clamp = (p16 > 16'sd16384) ? 16'sd16384 :
                   (p16 < -16'sd16384) ? -16'sd16384 : p16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ttc_pkg::S_FIN && fin_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ttc_pkg::S_FIN && fin_ok) begin
      roll_out_q  <= roll_r[31:16];
      pitch_out_q <= p_clamp;
      head_out_q  <= present_q ? head_r[31:16] - decl_q : 16'sd0;
      hv_out_q    <= present_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.roll          = roll_out_q;
  assign out_o.pitch         = pitch_out_q;
  assign out_o.heading       = head_out_q;
  assign out_o.heading_valid = hv_out_q;

`ifndef NO_ASSERTIONS
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pitch_out_q <= 16'sd16384) && (pitch_out_q >= -16'sd16384))
    else $error("pitch outside half turn");
  a_heading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hv_out_q |-> head_out_q == 16'sd0)
    else $error("heading set without field word");
  a_start_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && enable_q |=> state_q == ttc_pkg::S_SMUL)
    else $error("accepted word did not start smoothing");
  a_drop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !enable_q |=> state_q == ttc_pkg::S_IDLE)
    else $error("disabled word was not dropped");
`endif

endmodule

// ===== tb/ttc_tb_pkg.sv =====
package ttc_tb_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
    logic signed [15:0] field_z;
    logic               field_present;
    logic               restart;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] heading;
    logic               heading_valid;
  } angles_t;

endpackage

// ===== tb/ttc_tb_ifs.sv =====
// the block's channel interfaces are compiled from the rtl tree; this file
// carries the configuration bus shared by stimulus and checker
interface ttc_cfg_if;
  logic        we;
  logic [1:0]  idx;
  logic [15:0] data;
endinterface

// ===== tb/compass_checker.sv =====
module compass_checker
  import ttc_pkg::*;
  import ttc_tb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ttc_in_if     in_w,
  ttc_out_if    out_w,
  ttc_cfg_if    cfg_w,
  output int    errors_o,
  output int    pending_o
);

  logic               en_q;
  logic [15:0]        coef_q;
  logic [1:0]         rot_q;
  logic [15:0]        decl_q;
  logic signed [31:0] acc_avg [3];
  logic signed [31:0] fld_avg [3];
  logic               first_q;
  angles_t            angle_fifo [$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] vec_angle(longint y, longint x);
    logic [31:0] ang;
    longint dx, dy;
    ang = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; ang = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += ARC_TAB[i];
      end else begin
        x -= dx; y += dy; ang -= ARC_TAB[i];
      end
    end
    return ang;
  endfunction

  task automatic rotate_pair(inout longint a, inout longint b, input logic [31:0] ang);
    logic   flip;
    longint x, y, z, dx, dy, na;
    flip = ang[30] != ang[31];
    x = longint'(GAIN_Q30);
    y = 0;
    if (flip) ang = ang - HALF_TURN;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARC_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARC_TAB[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    na = floor_shift(a * x - b * y, 30);
    b = floor_shift(a * y + b * x, 30);
    a = na;
  endtask

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [15:0] round16(logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  function automatic longint to_fixed(logic signed [15:0] raw);
    longint s;
    s = raw;
    if (SAMPLE_BITS < 16) return ((s >>> (16 - SAMPLE_BITS)) <<< (16 - SAMPLE_BITS)) <<< 16;
    return s <<< (32 - SAMPLE_BITS);
  endfunction

  task automatic ema(inout logic signed [31:0] v, input longint s, input logic whole);
    longint cur;
    cur = v;
    if (whole) cur = s;
    else cur += floor_shift((s - cur) * longint'(coef_q), 16);
    v = cur[31:0];
  endtask

  task automatic screen_map(inout longint x, inout longint y);
    longint a, b;
    a = x; b = y;
    case (rot_q)
      2'd1: begin x = b;  y = -a; end
      2'd2: begin x = -a; y = -b; end
      2'd3: begin x = -b; y = a;  end
      default: ;
    endcase
  endtask

  task automatic predict_angles(input sample_t s);
    logic        whole;
    longint      x, y, z, p;
    logic [31:0] roll, pitch;
    angles_t     r;
    if (!en_q) return;
    whole = s.restart || first_q;
    first_q = 1'b0;
    ema(acc_avg[0], to_fixed(s.accel_x), whole);
    ema(acc_avg[1], to_fixed(s.accel_y), whole);
    ema(acc_avg[2], to_fixed(s.accel_z), whole);
    x = acc_avg[0]; y = acc_avg[1]; z = acc_avg[2];
    screen_map(x, y);
    roll = vec_angle(-x, y);
    pitch = vec_angle(-z, int_sqrt(longint'(x * x + y * y)));
    r.roll = round16(roll);
    p = longint'($signed(round16(pitch)));
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    r.pitch = p[15:0];
    r.heading = '0;
    r.heading_valid = 1'b0;
    if (s.field_present) begin
      ema(fld_avg[0], to_fixed(s.field_x), whole);
      ema(fld_avg[1], to_fixed(s.field_y), whole);
      ema(fld_avg[2], to_fixed(s.field_z), whole);
      x = fld_avg[0]; y = fld_avg[1]; z = fld_avg[2];
      screen_map(x, y);
      rotate_pair(x, y, 32'd0 - roll);
      rotate_pair(y, z, pitch);
      r.heading = round16(vec_angle(-x, z)) - decl_q;
      r.heading_valid = 1'b1;
    end
    angle_fifo.push_back(r);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors_o++;
  endtask

  assign pending_o = angle_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t s;
    angles_t e;
    if (!rst_ni) begin
      en_q <= 1'b0;
      coef_q <= 16'd655;
      rot_q <= '0;
      decl_q <= '0;
      first_q <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        acc_avg[i] <= '0; fld_avg[i] <= '0;
      end
      errors_o <= 0;
      angle_fifo.delete();
    end else begin
      if (cfg_w.we) begin
        case (cfg_idx_e'(cfg_w.idx))
          CFG_ENABLE: begin
            if (cfg_w.data[0] != en_q) first_q = 1'b1;
            en_q = cfg_w.data[0];
          end
          CFG_COEF: coef_q = cfg_w.data;
          CFG_ROT:  rot_q = cfg_w.data[1:0];
          CFG_DECL: decl_q = cfg_w.data;
          default: ;
        endcase
      end
      if (out_w.valid && out_w.ready) begin
        if (angle_fifo.size() == 0) report("unexpected word", 0, 0);
        else begin
          e = angle_fifo.pop_front();
          if (out_w.roll !== e.roll) report("roll", out_w.roll, e.roll);
          if (out_w.pitch !== e.pitch) report("pitch", out_w.pitch, e.pitch);
          if (out_w.heading_valid !== e.heading_valid)
            report("heading_valid", out_w.heading_valid, e.heading_valid);
          if (out_w.heading !== e.heading) report("heading", out_w.heading, e.heading);
        end
      end
      if (in_w.valid && in_w.ready) begin
        s = '{in_w.accel_x, in_w.accel_y, in_w.accel_z, in_w.field_x, in_w.field_y,
              in_w.field_z, in_w.field_present, in_w.restart};
        predict_angles(s);
      end
    end
  end

endmodule

// ===== tb/tilt_compensated_compass_test.sv =====
module tilt_compensated_compass_test;
  import ttc_pkg::*;
  import ttc_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;

  ttc_in_if  in_w ();
  ttc_out_if out_w ();
  ttc_cfg_if cfg_w ();

  tilt_compensated_compass u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_w),
    .out_o      (out_w),
    .cfg_we_i   (cfg_w.we),
    .cfg_idx_i  (cfg_w.idx),
    .cfg_data_i (cfg_w.data)
  );

  compass_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_w      (in_w),
    .out_w     (out_w),
    .cfg_w     (cfg_w),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_w.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_w.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_w.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #30_000_000;
    $display("tilt_compensated_compass_test: errors");
    $finish;
  end

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      3, 4: return $signed(16'($urandom_range(5000))) - 16'sd2500;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays up after the accepting edge; the next word replaces its data,
  // and an idle cycle or drain takes it down
  task automatic send_word(input sample_t s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid <= 1'b1;
    {in_w.accel_x, in_w.accel_y, in_w.accel_z, in_w.field_x, in_w.field_y,
     in_w.field_z, in_w.field_present, in_w.restart} <= s;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  task automatic send_axes(input int ax, input int ay, input int az, input logic fp,
                           input logic rs);
    sample_t s;
    s = '{16'(ax), 16'(ay), 16'(az), 16'($urandom), 16'($urandom), 16'($urandom), fp, rs};
    send_word(s);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_w.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // pending covers every enabled word and a dropped word gives none; this loop only adds margin
    while (n < 200) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_w.we <= 1'b1;
    cfg_w.idx <= idx;
    cfg_w.data <= val;
    @(posedge clk_i);
    cfg_w.we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_run(input int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.accel_x = pick_axis();
      s.accel_y = pick_axis();
      s.accel_z = pick_axis();
      s.field_x = pick_axis();
      s.field_y = pick_axis();
      s.field_z = pick_axis();
      s.field_present = $urandom_range(3) != 0;
      s.restart = $urandom_range(15) == 0;
      send_word(s);
    end
  endtask

  initial begin
    sample_t s;
    rst_ni = 1'b0;
    in_w.valid = 1'b0;
    {in_w.accel_x, in_w.accel_y, in_w.accel_z, in_w.field_x, in_w.field_y,
     in_w.field_z, in_w.field_present, in_w.restart} = '0;
    cfg_w.we = 1'b0;
    cfg_w.idx = CFG_ENABLE;
    cfg_w.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled: words dropped
    send_axes(100, 200, 300, 1'b1, 1'b0);
    send_axes(-100, 0, 16384, 1'b0, 1'b1);
    drain();
    write_reg(CFG_ENABLE, 16'd1);
    // zero vector, extremes, every axis sign
    send_axes(0, 0, 0, 1'b0, 1'b0);
    s = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1};
    send_word(s);
    s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1};
    send_word(s);
    s = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1};
    send_word(s);
    send_axes(0, 0, 2510, 1'b1, 1'b0);
    send_axes(0, 0, -2510, 1'b1, 1'b0);
    send_axes(2510, 0, 0, 1'b1, 1'b0);
    send_axes(-2510, 0, 0, 1'b0, 1'b0);
    send_axes(0, 2510, 0, 1'b1, 1'b0);
    send_axes(0, -2510, 0, 1'b1, 1'b1);
    drain();
    // toggling enable restarts smoothing
    write_reg(CFG_ENABLE, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_ROT, 16'd1);
    write_reg(CFG_DECL, 16'h8000);
    send_axes(1000, -500, 2000, 1'b1, 1'b0);
    drain();
    write_reg(CFG_ROT, 16'd2);
    write_reg(CFG_DECL, 16'h7fff);
    send_axes(1000, -500, 2000, 1'b1, 1'b0);
    drain();
    write_reg(CFG_ROT, 16'd3);
    write_reg(CFG_COEF, 16'hffff);
    send_axes(1000, -500, 2000, 1'b1, 1'b0);
    drain();
    write_reg(CFG_COEF, 16'd0);
    send_axes(-3000, 700, 100, 1'b1, 1'b0);
    drain();

    // random phases over settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_reg(CFG_COEF, (ph == 0) ? 16'd0 : (ph == 7) ? 16'hffff : 16'($urandom));
      write_reg(CFG_ROT, 16'(ph % 4));
      write_reg(CFG_DECL, 16'($urandom));
      if (ph == 5) write_reg(CFG_ENABLE, 16'd0);
      if (ph == 6) write_reg(CFG_ENABLE, 16'd1);
      if (ph == 3) hold_cycles = 2000;
      random_run(86);
      drain();
    end

    if (errors == 0) $display("tilt_compensated_compass_test: clean");
    else $display("tilt_compensated_compass_test: errors");
    $finish;
  end

endmodule
